// ===== rtl/pcmi_pkg.sv =====
package pcmi_pkg;

  // default palette depth
  localparam int PALETTE_SIZE_DEF = 256;

  // fixed field widths
  localparam int COLOR_W    = 8;
  localparam int ENTRY_W    = 3 * COLOR_W;
  localparam int ERR_W      = 10;
  localparam int INDEX_W    = 8;
  localparam int FILL_W     = 9;
  localparam int THR_W      = 10;
  localparam int MAXC_W     = 9;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_COLORS = 1'b1;

  // configuration reset values
  localparam logic [THR_W-1:0]  THR_RESET  = '0;
  localparam logic [MAXC_W-1:0] MAXC_RESET = 9'd256;

  // input kind codes
  localparam logic KIND_SEARCH = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic start;   // latch color, restart the walk
    logic clear;   // empty the palette, zero result
    logic scan;    // advance the walk by one entry
    logic finish;  // resolve the result at the end of the walk
    logic load;    // move the result into the output register
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic scan_done;
  } dp_sts_t;

endpackage

// ===== rtl/palette_color_match_insert_unit.sv =====
// Nearest palette color search with append. A search item walks the filled
// palette entries in index order, one entry per clock through a single
// registered read port of the palette memory, and returns the first entry
// whose Manhattan RGB error is below color_threshold; failing that it appends
// the color while fewer than min(max_colors, PALETTE_SIZE) entries are used,
// else returns the first entry of least error. The walk ends early on a hit.
// A clear item empties the palette and returns a zero result. The result
// waits in an output register, so the next item is accepted while it stalls.
// Configuration is always ready; the user must see that it is written only
// while the block is idle, as the block itself does not enforce this.
module palette_color_match_insert_unit #(
  parameter int PALETTE_SIZE = pcmi_pkg::PALETTE_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pcmi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcmi_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [pcmi_pkg::COLOR_W-1:0]    in_red,
  input  logic [pcmi_pkg::COLOR_W-1:0]    in_green,
  input  logic [pcmi_pkg::COLOR_W-1:0]    in_blue,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pcmi_pkg::INDEX_W-1:0]    out_index,
  output logic                            out_inserted,
  output logic                            out_early_hit,
  output logic [pcmi_pkg::FILL_W-1:0]     out_fill_count
);

  pcmi_pkg::dp_cmd_t cmd;
  pcmi_pkg::dp_sts_t sts;
  logic              cfg_we;

  // register writes never wait
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  pcmi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_kind   (in_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pcmi_datapath #(
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .cmd            (cmd),
    .sts            (sts),
    .out_index      (out_index),
    .out_inserted   (out_inserted),
    .out_early_hit  (out_early_hit),
    .out_fill_count (out_fill_count)
  );

endmodule

// ===== rtl/pcmi_ctrl.sv =====
module pcmi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_kind,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  pcmi_pkg::dp_sts_t sts,
  output pcmi_pkg::dp_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_take;
  logic   slot_free;

  // input is taken only between items; output slot is separate
  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign slot_free = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          if (in_kind == pcmi_pkg::KIND_CLEAR) begin
            cmd.clear = 1'b1;
            state_nxt = S_DONE;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          cmd.finish = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DONE: begin
        if (slot_free) begin
          cmd.load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output slot occupancy
  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/pcmi_datapath.sv =====
module pcmi_datapath #(
  parameter int PALETTE_SIZE = pcmi_pkg::PALETTE_SIZE_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [pcmi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcmi_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [pcmi_pkg::COLOR_W-1:0]    in_red,
  input  logic [pcmi_pkg::COLOR_W-1:0]    in_green,
  input  logic [pcmi_pkg::COLOR_W-1:0]    in_blue,
  input  pcmi_pkg::dp_cmd_t               cmd,
  output pcmi_pkg::dp_sts_t               sts,
  output logic [pcmi_pkg::INDEX_W-1:0]    out_index,
  output logic                            out_inserted,
  output logic                            out_early_hit,
  output logic [pcmi_pkg::FILL_W-1:0]     out_fill_count
);

  localparam int IDX_W = $clog2(PALETTE_SIZE);
  localparam int CNT_W = $clog2(PALETTE_SIZE + 1);
  localparam int CW    = pcmi_pkg::COLOR_W;

  // palette storage
  logic [pcmi_pkg::ENTRY_W-1:0] mem [PALETTE_SIZE];
  logic [pcmi_pkg::ENTRY_W-1:0] rd_data_r;

  // configuration
  logic [pcmi_pkg::THR_W-1:0]  thr_r;
  logic [pcmi_pkg::MAXC_W-1:0] maxc_r;

  // walk control
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             rv_r;
  logic [IDX_W-1:0] ridx_r;

  // walk payload
  logic [pcmi_pkg::ENTRY_W-1:0] color_r;
  logic [pcmi_pkg::ERR_W-1:0]   best_err_r;
  logic [IDX_W-1:0]             best_idx_r;

  // resolved result and output register
  logic [pcmi_pkg::INDEX_W-1:0] res_idx_r;
  logic                         res_ins_r;
  logic                         res_hit_r;
  logic [pcmi_pkg::FILL_W-1:0]  res_fill_r;
  logic [pcmi_pkg::INDEX_W-1:0] out_idx_r;
  logic                         out_ins_r;
  logic                         out_hit_r;
  logic [pcmi_pkg::FILL_W-1:0]  out_fill_r;

  logic [CNT_W-1:0]           room_c;
  logic                       has_room;
  logic                       issue_en;
  logic                       wr_en;
  logic [CW-1:0]              d_red, d_green, d_blue;
  logic [pcmi_pkg::ERR_W-1:0] err_c;
  logic                       hit_now;
  logic                       better;
  logic [IDX_W-1:0]           best_sel;
  logic [IDX_W-1:0]           res_idx_c;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    abs_diff = (a > b) ? (a - b) : (b - a);
  endfunction

  // usable room, max_colors saturates at the palette depth
  assign room_c = (maxc_r > pcmi_pkg::MAXC_W'(PALETTE_SIZE)) ? CNT_W'(PALETTE_SIZE)
                                                            : CNT_W'(maxc_r);
  assign has_room = (used_r < room_c);

  // manhattan error of the entry read last cycle
  assign d_red   = abs_diff(rd_data_r[3*CW-1:2*CW], color_r[3*CW-1:2*CW]);
  assign d_green = abs_diff(rd_data_r[2*CW-1:CW],   color_r[2*CW-1:CW]);
  assign d_blue  = abs_diff(rd_data_r[CW-1:0],      color_r[CW-1:0]);
  assign err_c   = pcmi_pkg::ERR_W'(d_red) + pcmi_pkg::ERR_W'(d_green)
                 + pcmi_pkg::ERR_W'(d_blue);

  // first entry under threshold wins, otherwise track first least error
  assign hit_now  = rv_r && (err_c < thr_r);
  assign better   = rv_r && (err_c < best_err_r);
  assign best_sel = better ? ridx_r : best_idx_r;

  assign issue_en = cmd.scan && (cnt_r < used_r);
  assign wr_en    = cmd.finish && !hit_now && has_room;

  assign sts.scan_done = hit_now || (cnt_r >= used_r);

  // resolution at the end of the walk
  always_comb begin
    used_nxt = used_r;
    if (hit_now) begin
      res_idx_c = ridx_r;
    end else if (has_room) begin
      res_idx_c = used_r[IDX_W-1:0];
      used_nxt  = CNT_W'(used_r + 1'b1);
    end else begin
      res_idx_c = best_sel;
    end
  end

  // palette memory, registered read
  always_ff @(posedge clk) begin
    if (issue_en) begin
      rd_data_r <= mem[cnt_r[IDX_W-1:0]];
    end
    if (wr_en) begin
      mem[used_r[IDX_W-1:0]] <= color_r;
    end
  end

  // control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= pcmi_pkg::THR_RESET;
      maxc_r <= pcmi_pkg::MAXC_RESET;
      used_r <= '0;
      cnt_r  <= '0;
      rv_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pcmi_pkg::CFG_THRESHOLD:  thr_r  <= pcmi_pkg::THR_W'(cfg_data);
          pcmi_pkg::CFG_MAX_COLORS: maxc_r <= pcmi_pkg::MAXC_W'(cfg_data);
          default: ;
        endcase
      end
      if (cmd.clear) begin
        used_r <= '0;
      end else if (cmd.start) begin
        cnt_r <= '0;
        rv_r  <= 1'b0;
      end else if (cmd.finish) begin
        rv_r   <= 1'b0;
        used_r <= used_nxt;
      end else if (cmd.scan) begin
        rv_r <= issue_en;
        if (issue_en) begin
          cnt_r <= CNT_W'(cnt_r + 1'b1);
        end
      end
    end
  end

  // walk payload, result and output registers
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      color_r    <= {in_red, in_green, in_blue};
      best_err_r <= '1;
      best_idx_r <= '0;
    end else if (cmd.finish) begin
      res_idx_r  <= pcmi_pkg::INDEX_W'(res_idx_c);
      res_ins_r  <= !hit_now && has_room;
      res_hit_r  <= hit_now;
      res_fill_r <= pcmi_pkg::FILL_W'(used_nxt);
    end else if (cmd.scan) begin
      ridx_r <= cnt_r[IDX_W-1:0];
      if (better) begin
        best_err_r <= err_c;
        best_idx_r <= ridx_r;
      end
    end
    if (cmd.clear) begin
      res_idx_r  <= '0;
      res_ins_r  <= 1'b0;
      res_hit_r  <= 1'b0;
      res_fill_r <= '0;
    end
    if (cmd.load) begin
      out_idx_r  <= res_idx_r;
      out_ins_r  <= res_ins_r;
      out_hit_r  <= res_hit_r;
      out_fill_r <= res_fill_r;
    end
  end

  assign out_index      = out_idx_r;
  assign out_inserted   = out_ins_r;
  assign out_early_hit  = out_hit_r;
  assign out_fill_count = out_fill_r;

endmodule

// ===== rtl/pcmi_checker.sv =====
module pcmi_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [pcmi_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [pcmi_pkg::CFG_DATA_W-1:0] cfg_data,
  input logic                            in_valid,
  input logic                            in_stall,
  input logic                            in_kind,
  input logic [pcmi_pkg::COLOR_W-1:0]    in_red,
  input logic [pcmi_pkg::COLOR_W-1:0]    in_green,
  input logic [pcmi_pkg::COLOR_W-1:0]    in_blue,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [pcmi_pkg::INDEX_W-1:0]    out_index,
  input logic                            out_inserted,
  input logic                            out_early_hit,
  input logic [pcmi_pkg::FILL_W-1:0]     out_fill_count
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_index) &&
    $stable(out_fill_count) && $stable(out_inserted) && $stable(out_early_hit))
    else $error("stalled result changed");

  // one item at a time: input closes right after an accept
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input open right after accept");

  // append and early hit exclude each other
  a_ins_excl_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_inserted && out_early_hit))
    else $error("inserted and early hit both set");

  // appended entry is the last one in use
  a_ins_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_inserted |->
    out_fill_count == pcmi_pkg::FILL_W'({1'b0, out_index} + 9'd1))
    else $error("appended index does not match fill count");

  // a returned entry lies inside the filled palette
  a_idx_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fill_count != '0 |->
    pcmi_pkg::FILL_W'(out_index) < out_fill_count)
    else $error("index beyond fill count");

endmodule

bind palette_color_match_insert_unit pcmi_checker u_pcmi_checker (.*);

// ===== sim/palette_color_match_insert_unit_tb.sv =====
`timescale 1ns / 100ps

module palette_color_match_insert_unit_tb;
  import pcmi_pkg::*;

  localparam int PSIZE          = PALETTE_SIZE_DEF;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct {
    logic [INDEX_W-1:0] index;
    logic               inserted;
    logic               early_hit;
    logic [FILL_W-1:0]  fill_count;
  } match_t;

  // palette predictor and store of pending match results
  class palette_scoreboard;
    logic [ENTRY_W-1:0] entries [PSIZE];
    int unsigned        fill;
    int unsigned        threshold;
    int unsigned        max_colors;
    match_t             expected_matches [$];
    int                 failures;

    function new();
      fill       = 0;
      threshold  = THR_RESET;
      max_colors = MAXC_RESET;
      failures   = 0;
    endfunction

    function void set_register(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_THRESHOLD:  threshold  = data[THR_W-1:0];
        CFG_MAX_COLORS: max_colors = data[MAXC_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned channel_error(input logic [COLOR_W-1:0] a, b);
      return (a > b) ? int'(a - b) : int'(b - a);
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction

    // walk the filled entries like the block does and queue the outcome
    function void note_item(input logic kind, input logic [COLOR_W-1:0] r, g, b);
      match_t             m;
      int unsigned        room, best_err, err, best_idx;
      logic [ENTRY_W-1:0] e;
      bit                 hit;
      m = '{default: '0};
      hit = 1'b0;
      best_err = 32'hFFFF;
      best_idx = 0;
      room = (max_colors > PSIZE) ? PSIZE : max_colors;
      if (kind == KIND_CLEAR) begin
        fill = 0;
      end else begin
        for (int i = 0; i < fill; i++) begin
          e = entries[i];
          err = channel_error(e[23:16], r) + channel_error(e[15:8], g)
              + channel_error(e[7:0], b);
          if (err < best_err) begin
            if (err < threshold) begin
              hit = 1'b1;
              m.index = 8'(i);
              break;
            end
            best_err = err;
            best_idx = i;
          end
        end
        if (!hit) begin
          if (fill < room) begin
            entries[fill] = {r, g, b};
            m.index = 8'(fill);
            m.inserted = 1'b1;
            fill++;
          end else begin
            m.index = 8'(best_idx);
          end
        end
        m.early_hit = hit;
      end
      m.fill_count = 9'(fill);
      expected_matches.push_back(m);
    endfunction

    function void compare_field(input string name, input logic [31:0] want, got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        failures++;
      end
    endfunction

    function void check_result(input match_t got);
      match_t want;
      if (expected_matches.size() == 0) begin
        $error("result with no item pending: index %0d fill_count %0d",
               got.index, got.fill_count);
        failures++;
        return;
      end
      want = expected_matches.pop_front();
      compare_field("index", want.index, got.index);
      compare_field("inserted", want.inserted, got.inserted);
      compare_field("early_hit", want.early_hit, got.early_hit);
      compare_field("fill_count", want.fill_count, got.fill_count);
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic                  in_kind        = KIND_SEARCH;
  logic [COLOR_W-1:0]    in_red         = '0;
  logic [COLOR_W-1:0]    in_green       = '0;
  logic [COLOR_W-1:0]    in_blue        = '0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [INDEX_W-1:0]    out_index;
  logic                  out_inserted;
  logic                  out_early_hit;
  logic [FILL_W-1:0]     out_fill_count;

  palette_scoreboard sb;
  int                silent_cycles = 0;
  bit                accepted;
  int                stall_left    = 0;
  int                stall_pct     = 0;

  palette_color_match_insert_unit #(
    .PALETTE_SIZE(PSIZE)
  ) DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_red        (in_red),
    .in_green      (in_green),
    .in_blue       (in_blue),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_index     (out_index),
    .out_inserted  (out_inserted),
    .out_early_hit (out_early_hit),
    .out_fill_count(out_fill_count)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // receiver stall pattern, switching between stretches of different density
  always @(negedge clk) begin
    if (stall_left == 0) begin
      case ($urandom_range(0, 3))
        0, 1:    stall_pct = 0;
        2:       stall_pct = 30;
        default: stall_pct = 70;
      endcase
      stall_left = $urandom_range(50, 400);
    end
    stall_left--;
    out_stall = ($urandom_range(0, 99) < stall_pct);
  end

  // handshake monitor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      accepted = 1'b0;
      if (cfg_valid && cfg_ready) begin
        sb.set_register(cfg_index, cfg_data);
        accepted = 1'b1;
      end
      if (in_valid && !in_stall) begin
        sb.note_item(in_kind, in_red, in_green, in_blue);
        accepted = 1'b1;
      end
      if (out_valid && !out_stall) begin
        sb.check_result('{out_index, out_inserted, out_early_hit, out_fill_count});
        accepted = 1'b1;
      end
      silent_cycles = accepted ? 0 : silent_cycles + 1;
      if (silent_cycles >= WATCHDOG_LIMIT) begin
        $display("palette_color_match_insert_unit test failed");
        $finish;
      end
    end
  end

  // random color: uniform, close to a stored entry, or from a coarse grid for ties
  function automatic logic [ENTRY_W-1:0] pick_color();
    logic [ENTRY_W-1:0] c;
    int                 mode, v;
    mode = $urandom_range(0, 9);
    c = ENTRY_W'($urandom);
    if (mode >= 4 && mode <= 6 && sb.fill > 0) begin
      c = sb.entries[$urandom_range(0, sb.fill - 1)];
      for (int k = 0; k < 3; k++) begin
        v = int'(c[k*8 +: 8]) + int'($urandom_range(0, 8)) - 4;
        c[k*8 +: 8] = (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : 8'(v);
      end
    end else if (mode >= 7) begin
      for (int k = 0; k < 3; k++) begin
        c[k*8 +: 8] = 8'(85 * $urandom_range(0, 3));
      end
    end
    return c;
  endfunction

  task automatic send_item(input logic kind, input logic [ENTRY_W-1:0] color);
    @(negedge clk);
    in_valid = 1'b1;
    in_kind  = kind;
    {in_red, in_green, in_blue} = color;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic pause_sender(input int cycles);
    @(negedge clk);
    in_valid = 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // hold the sender until every pending match has come back
  task automatic wait_for_matches();
    pause_sender(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = CFG_DATA_W'(value);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic configure(input int unsigned thr, input int unsigned maxc);
    wait_for_matches();
    write_register(CFG_THRESHOLD, thr);
    write_register(CFG_MAX_COLORS, maxc);
  endtask

  // bursts of random length with random gaps in between
  task automatic run_random(input int items, input int clear_pct);
    int burst;
    burst = 0;
    repeat (items) begin
      if (burst == 0) begin
        pause_sender($urandom_range(1, 6));
        burst = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                            : $urandom_range(1, 12);
      end
      burst--;
      send_item(($urandom_range(0, 99) < clear_pct) ? KIND_CLEAR : KIND_SEARCH,
                pick_color());
    end
  endtask

  initial begin
    int unsigned thr, maxc;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // reset settings: zero threshold never hits, so duplicates append
    send_item(KIND_SEARCH, 24'h000000);
    send_item(KIND_SEARCH, 24'hFFFFFF);
    send_item(KIND_SEARCH, 24'h000000);
    send_item(KIND_CLEAR, 24'hFFFFFF);

    // empty palette with no room
    configure(0, 0);
    send_item(KIND_SEARCH, 24'h123456);

    // two entries, exact hit, ties go to the lower index, nearest entry
    configure(1, 2);
    send_item(KIND_SEARCH, 24'hFF0000);
    send_item(KIND_SEARCH, 24'h00FF00);
    send_item(KIND_SEARCH, 24'hFF0000);
    send_item(KIND_SEARCH, 24'h0000FF);
    send_item(KIND_SEARCH, 24'h808000);
    send_item(KIND_SEARCH, 24'h00C800);

    // capacity below the fill count
    configure(1, 1);
    send_item(KIND_SEARCH, 24'h00F000);

    // widest threshold and a capacity above the palette size
    configure(766, 511);
    send_item(KIND_CLEAR, 24'h000000);
    send_item(KIND_SEARCH, 24'h000000);
    send_item(KIND_SEARCH, 24'hFFFFFF);
    send_item(KIND_SEARCH, 24'h7F807F);

    // fill the whole palette, then search it while full
    configure(0, 256);
    run_random(380, 0);

    configure(766, 511);
    run_random(60, 5);

    // mixed settings
    repeat (12) begin
      case ($urandom_range(0, 4))
        0:       thr = 0;
        1:       thr = 1;
        2:       thr = $urandom_range(2, 60);
        3:       thr = $urandom_range(0, 766);
        default: thr = 766;
      endcase
      case ($urandom_range(0, 6))
        0:       maxc = 0;
        1:       maxc = 1;
        2:       maxc = $urandom_range(2, 32);
        3:       maxc = $urandom_range(0, 256);
        4:       maxc = 256;
        5:       maxc = $urandom_range(257, 511);
        default: maxc = PSIZE - 1;
      endcase
      configure(thr, maxc);
      run_random(80, 4);
    end

    configure(40, 256);
    run_random(150, 2);

    wait_for_matches();
    repeat (PSIZE + 8) @(posedge clk);
    if (sb.failures == 0) begin
      $display("palette_color_match_insert_unit test passed");
    end else begin
      $display("palette_color_match_insert_unit test failed");
    end
    $finish;
  end

endmodule
